// ===== hw/rtl/wfcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfcs_pkg: shared types and constants
// Payload structs, command and status codes of the class scheduler.
// ----------------------------------------------------------------------------
package wfcs_pkg;

    localparam int VT_W   = 48;
    localparam int WGT_W  = 16;
    localparam int AMT_W  = 32;
    localparam int DIV_W  = AMT_W + 24;
    localparam logic [WGT_W-1:0] WEIGHT_ONE = 16'd256;
    localparam logic [VT_W-1:0]  THRESH_RESET = 48'h0100_0000_0000;

    typedef enum logic [2:0] {
        MODE_ACTIVATE   = 3'd0,
        MODE_DEACTIVATE = 3'd1,
        MODE_SET_PRIO   = 3'd2,
        MODE_SELECT     = 3'd3,
        MODE_CHARGE     = 3'd4,
        MODE_ADMIT      = 3'd5,
        MODE_RETIRE     = 3'd6,
        MODE_REMOVE     = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UNKNOWN    = 3'd1,
        ST_NOT_ACTIVE = 3'd2,
        ST_REFUSED    = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  class_index;
        logic [15:0] head_priority;
        logic [31:0] amount;
        logic [15:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        selected_valid;
        logic [3:0]  selected_class;
        logic        class_present;
        logic        class_accepting;
        logic        class_active;
        logic [15:0] class_weight;
    } t_out_item;

    // Divider control between sequencer and divide unit
    typedef struct packed {
        logic              start;
        logic [AMT_W-1:0]  amount;
        logic [WGT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== hw/rtl/weighted_fair_class_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_fair_class_scheduler: virtual-time fair class scheduler
// Class table with weights, 32.16 virtual times and head priorities; one
// command per input transfer, one result transfer per command.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  input    | in        | i_in_valid/o_in_stall   | t_in_item
//  output   | out       | o_out_valid/i_out_stall | t_out_item
//  config   | in        | APB write/read    | renorm_threshold at 0x0 (48 bit)
//
// Select and the renormalise and idle-reset passes walk the table one class a
// cycle; charge runs the bit-serial divide. o_in_stall stays high until the
// result is loaded into the output register, and a command waits there while
// an earlier result is still stalled. Reset is synchronous and leaves only
// class 0 in the table, present and accepting.
// ----------------------------------------------------------------------------
module weighted_fair_class_scheduler import wfcs_pkg::*; #(
    parameter int NUM_CLASSES   = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CNT_W = $clog2(NUM_CLASSES + 1);
    localparam logic [VT_W-1:0] VT_MAX = '1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_RENRM = 7'b0010000,
        S_IDLRS = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // Class table
    logic [NUM_CLASSES-1:0]   r_present, r_accepting, r_active;
    logic [WGT_W-1:0]         r_weight [NUM_CLASSES];
    logic [VT_W-1:0]          r_vtime  [NUM_CLASSES];
    logic [PRIORITY_BITS-1:0] r_prio   [NUM_CLASSES];
    logic [VT_W-1:0]          r_sysvt;
    logic [VT_W-1:0]          r_thresh;

    t_state          r_state;
    t_in_item        r_cmd;
    logic [IDX_W-1:0] r_cidx;
    logic            r_intab;
    logic [CNT_W-1:0] r_cnt;
    logic            r_found;
    logic [IDX_W-1:0] r_best;
    logic [VT_W-1:0] r_bvt;
    logic [PRIORITY_BITS-1:0] r_bpr;
    logic            r_idle_chk;
    logic [2:0]      r_status;
    logic            r_selv;
    logic [3:0]      r_selc;
    t_out_item       r_out;
    logic            r_ovalid;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    wire logic w_in_acc = i_in_valid && !o_in_stall;
    wire logic [IDX_W-1:0] w_scan = r_cnt[IDX_W-1:0];
    wire logic w_known = r_intab && r_present[r_cidx];
    wire logic [PRIORITY_BITS-1:0] w_prio = PRIORITY_BITS'(r_cmd.head_priority);
    wire logic w_cfg_wr = psel && penable && pwrite;

    logic [NUM_CLASSES-1:0] w_others;
    always_comb begin
        w_others = r_active;
        w_others[r_cidx] = 1'b0;
    end

    logic [VT_W:0] w_sum;
    assign w_sum = {1'b0, r_vtime[r_cidx]} + {1'b0, w_drsp.quotient[VT_W-1:0]};
    wire logic w_qbig = |w_drsp.quotient[DIV_W-1:VT_W];

    wfcs_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign w_dreq.start   = (r_state == S_EXEC) && w_known &&
                            (t_mode'(r_cmd.mode) == MODE_CHARGE);
    assign w_dreq.amount  = r_cmd.amount;
    assign w_dreq.divisor = r_cmd.weight;

    // Configuration register
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr == 4'd0) prdata = {16'd0, r_thresh};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (w_cfg_wr && paddr == 4'd0) begin
            r_thresh <= pwdata[VT_W-1:0];
        end
    end

    // Sequencer and table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= NUM_CLASSES'(1);
            r_accepting <= NUM_CLASSES'(1);
            r_active    <= '0;
            r_sysvt     <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_weight[i] <= WEIGHT_ONE;
                r_vtime[i]  <= '0;
                r_prio[i]   <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd    <= i_in_data;
                        r_cidx   <= IDX_W'(i_in_data.class_index);
                        r_intab  <= 32'(i_in_data.class_index) < NUM_CLASSES;
                        r_status <= ST_OK;
                        r_selv   <= 1'b0;
                        r_selc   <= '0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    r_state <= S_OUT;
                    priority if (t_mode'(r_cmd.mode) == MODE_SELECT) begin
                        r_state <= S_SCAN;
                    end else if (t_mode'(r_cmd.mode) == MODE_ADMIT) begin
                        if (!r_intab) begin
                            r_status <= ST_FULL;
                        end else begin
                            if (!r_present[r_cidx]) begin
                                r_present[r_cidx] <= 1'b1;
                                r_active[r_cidx]  <= 1'b0;
                                r_vtime[r_cidx]   <= r_sysvt;
                                r_prio[r_cidx]    <= '0;
                            end
                            r_accepting[r_cidx] <= 1'b1;
                            r_weight[r_cidx] <= (r_cidx == '0) ? WEIGHT_ONE : r_cmd.weight;
                        end
                    end else if (!w_known) begin
                        r_status <= ST_UNKNOWN;
                    end else begin
                        unique case (t_mode'(r_cmd.mode))
                            MODE_ACTIVATE: begin
                                if (!r_active[r_cidx]) begin
                                    if (|w_others && r_vtime[r_cidx] < r_sysvt)
                                        r_vtime[r_cidx] <= r_sysvt;
                                    r_active[r_cidx] <= 1'b1;
                                end
                                r_prio[r_cidx] <= w_prio;
                            end
                            MODE_DEACTIVATE: begin
                                r_active[r_cidx] <= 1'b0;
                                if (!(|w_others)) r_state <= S_IDLRS;
                            end
                            MODE_SET_PRIO: begin
                                if (r_active[r_cidx]) r_prio[r_cidx] <= w_prio;
                                else r_status <= ST_NOT_ACTIVE;
                            end
                            MODE_CHARGE: r_state <= S_DIV;
                            MODE_RETIRE: begin
                                if (r_cidx != '0) r_accepting[r_cidx] <= 1'b0;
                            end
                            default: begin
                                if (r_cidx == '0 || r_accepting[r_cidx] ||
                                    r_active[r_cidx]) begin
                                    r_status <= ST_REFUSED;
                                end else begin
                                    r_present[r_cidx]   <= 1'b0;
                                    r_accepting[r_cidx] <= 1'b0;
                                    r_active[r_cidx]    <= 1'b0;
                                    r_weight[r_cidx]    <= WEIGHT_ONE;
                                    r_vtime[r_cidx]     <= '0;
                                    r_prio[r_cidx]      <= '0;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Compare one class against the running best
                    if (r_active[w_scan] && (!r_found || r_vtime[w_scan] < r_bvt ||
                        (r_vtime[w_scan] == r_bvt && r_prio[w_scan] < r_bpr))) begin
                        r_found <= 1'b1;
                        r_best  <= w_scan;
                        r_bvt   <= r_vtime[w_scan];
                        r_bpr   <= r_prio[w_scan];
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NUM_CLASSES - 1)) begin
                        r_cnt <= '0;
                        r_idle_chk <= 1'b0;
                        r_state <= S_OUT;
                    end
                    if (r_cnt == CNT_W'(NUM_CLASSES)) begin
                        r_cnt <= '0;
                    end
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_vtime[r_cidx] <= (w_sum[VT_W] || w_qbig) ? VT_MAX
                                                                  : w_sum[VT_W-1:0];
                        r_idle_chk <= 1'b1;
                        r_cnt <= '0;
                        r_state <= (r_sysvt > r_thresh) ? S_RENRM
                                 : (|r_active) ? S_OUT : S_IDLRS;
                    end
                end
                S_RENRM: begin
                    // Shift one active class down by the system time; clear an inactive one
                    if (r_active[w_scan])
                        r_vtime[w_scan] <= (r_vtime[w_scan] > r_sysvt) ?
                                           r_vtime[w_scan] - r_sysvt : '0;
                    else
                        r_vtime[w_scan] <= '0;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NUM_CLASSES - 1)) begin
                        r_cnt   <= '0;
                        r_sysvt <= '0;
                        r_state <= (r_idle_chk && !(|r_active)) ? S_IDLRS : S_OUT;
                    end
                end
                S_IDLRS: begin
                    // Clear one class time
                    r_vtime[w_scan] <= '0;
                    r_sysvt <= '0;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NUM_CLASSES - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Select hit sets system time and may renormalise; then load result
                    if (t_mode'(r_cmd.mode) == MODE_SELECT && r_found) begin
                        r_found <= 1'b0;
                        r_selv  <= 1'b1;
                        r_selc  <= 4'(r_best);
                        r_sysvt <= r_bvt;
                        r_cnt   <= '0;
                        if (r_bvt > r_thresh) r_state <= S_RENRM;
                    end else if (!r_ovalid || !i_out_stall) begin
                        r_out.status          <= r_status;
                        r_out.selected_valid  <= r_selv;
                        r_out.selected_class  <= r_selc;
                        r_out.class_present   <= r_intab && r_present[r_cidx];
                        r_out.class_accepting <= r_intab && r_accepting[r_cidx];
                        r_out.class_active    <= r_intab && r_active[r_cidx];
                        r_out.class_weight    <= r_intab ? r_weight[r_cidx] : '0;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Drop the result once transferred
            if (r_ovalid && !i_out_stall && !(r_state == S_OUT &&
                !(t_mode'(r_cmd.mode) == MODE_SELECT && r_found)))
                r_ovalid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/wfcs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfcs_divider: restoring divider
// Computes floor((amount << 24) / divisor), one quotient bit per cycle; a zero divisor counts as one.
// ----------------------------------------------------------------------------
module wfcs_divider import wfcs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [WGT_W:0]   r_rem, n_rem;
    logic [WGT_W-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WGT_W:0]   w_trial;

    // Load a new division on start; otherwise shift in the next dividend bit and try a subtract
    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem[WGT_W-1:0], r_quo[DIV_W-1]};
        if (i_req.start) begin
            n_quo  = {i_req.amount, 24'd0};
            n_rem  = '0;
            n_dvs  = (i_req.divisor == '0) ? WGT_W'(1) : i_req.divisor;
            n_cnt  = CNT_W'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

// ===== sim/weighted_fair_class_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_fair_class_scheduler_tb: regression for the class scheduler
// Drives commands with random gaps and output stalls, predicts each result
// from a behavioural copy of the class table and checks it field by field.
// ----------------------------------------------------------------------------
module weighted_fair_class_scheduler_tb;
    import wfcs_pkg::*;

    localparam int NCLS = 16;
    localparam logic [47:0] VT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [3:0] ADDR_THRESH = 4'h0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    weighted_fair_class_scheduler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow class table
    logic        cls_present [NCLS];
    logic        cls_accepting [NCLS];
    logic        cls_active [NCLS];
    logic [15:0] cls_weight [NCLS];
    logic [47:0] cls_vtime [NCLS];
    logic [15:0] cls_prio [NCLS];
    logic [47:0] sys_vtime;
    logic [47:0] thresh;

    t_out_item   pending_results[$];
    int          error_count = 0;
    bit          hold_off = 1'b0;
    int          stall_bias = 2;

    function automatic void table_reset();
        for (int i = 0; i < NCLS; i++) begin
            cls_present[i] = 1'b0; cls_accepting[i] = 1'b0; cls_active[i] = 1'b0;
            cls_weight[i] = WEIGHT_ONE; cls_vtime[i] = '0; cls_prio[i] = '0;
        end
        cls_present[0] = 1'b1;
        cls_accepting[0] = 1'b1;
        sys_vtime = '0;
        thresh = THRESH_RESET;
    endfunction

    function automatic bit others_active(int skip);
        for (int i = 0; i < NCLS; i++)
            if (i != skip && cls_active[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void clear_if_idle();
        if (others_active(NCLS)) return;
        sys_vtime = '0;
        for (int i = 0; i < NCLS; i++) cls_vtime[i] = '0;
    endfunction

    function automatic void shift_times();
        logic [47:0] sh;
        sh = sys_vtime;
        if (sh <= thresh) return;
        for (int i = 0; i < NCLS; i++)
            cls_vtime[i] = (cls_active[i] && cls_vtime[i] > sh) ? cls_vtime[i] - sh : '0;
        sys_vtime = '0;
    endfunction

    // apply one command to the shadow table and return the expected result
    function automatic t_out_item schedule_command(t_in_item it);
        t_out_item r;
        int c;
        int best;
        bit found;
        logic [15:0] dv;
        logic [63:0] delta;
        logic [63:0] sum;
        r = '0;
        c = int'(it.class_index);
        found = 1'b0;
        best = 0;
        case (t_mode'(it.mode))
            MODE_SELECT: begin
                for (int i = 0; i < NCLS; i++) begin
                    if (!cls_active[i]) continue;
                    if (!found || cls_vtime[i] < cls_vtime[best] ||
                        (cls_vtime[i] == cls_vtime[best] && cls_prio[i] < cls_prio[best])) begin
                        best = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    sys_vtime = cls_vtime[best];
                    shift_times();
                    r.selected_valid = 1'b1;
                    r.selected_class = best[3:0];
                end
            end
            MODE_ADMIT: begin
                if (!cls_present[c]) begin
                    cls_present[c] = 1'b1; cls_active[c] = 1'b0;
                    cls_vtime[c] = sys_vtime; cls_prio[c] = '0;
                end
                cls_accepting[c] = 1'b1;
                cls_weight[c] = (c == 0) ? WEIGHT_ONE : it.weight;
            end
            default: begin
                if (!cls_present[c]) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    case (t_mode'(it.mode))
                        MODE_ACTIVATE: begin
                            if (!cls_active[c]) begin
                                if (others_active(c) && cls_vtime[c] < sys_vtime)
                                    cls_vtime[c] = sys_vtime;
                                cls_active[c] = 1'b1;
                            end
                            cls_prio[c] = it.head_priority;
                        end
                        MODE_DEACTIVATE: begin
                            cls_active[c] = 1'b0;
                            clear_if_idle();
                        end
                        MODE_SET_PRIO: begin
                            if (cls_active[c]) cls_prio[c] = it.head_priority;
                            else r.status = ST_NOT_ACTIVE;
                        end
                        MODE_CHARGE: begin
                            dv = (it.weight == 0) ? 16'd1 : it.weight;
                            delta = ({32'd0, it.amount} << 24) / {48'd0, dv};
                            sum = {16'd0, cls_vtime[c]} + delta;
                            cls_vtime[c] = (sum > {16'd0, VT_MAX}) ? VT_MAX : sum[47:0];
                            shift_times();
                            clear_if_idle();
                        end
                        MODE_RETIRE: begin
                            if (c != 0) cls_accepting[c] = 1'b0;
                        end
                        default: begin
                            if (c == 0 || cls_accepting[c] || cls_active[c]) begin
                                r.status = ST_REFUSED;
                            end else begin
                                cls_present[c] = 1'b0; cls_accepting[c] = 1'b0;
                                cls_active[c] = 1'b0; cls_weight[c] = WEIGHT_ONE;
                                cls_vtime[c] = '0; cls_prio[c] = '0;
                            end
                        end
                    endcase
                end
            end
        endcase
        r.class_present = cls_present[c];
        r.class_accepting = cls_accepting[c];
        r.class_active = cls_active[c];
        r.class_weight = cls_weight[c];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_out_data), 64'(0));
            end else begin
                w = pending_results.pop_front();
                if (o_out_data.status !== w.status)
                    report_mismatch("status", 64'(o_out_data.status), 64'(w.status));
                if (o_out_data.selected_valid !== w.selected_valid)
                    report_mismatch("selected_valid", 64'(o_out_data.selected_valid),
                                    64'(w.selected_valid));
                if (o_out_data.selected_class !== w.selected_class)
                    report_mismatch("selected_class", 64'(o_out_data.selected_class),
                                    64'(w.selected_class));
                if (o_out_data.class_present !== w.class_present)
                    report_mismatch("class_present", 64'(o_out_data.class_present),
                                    64'(w.class_present));
                if (o_out_data.class_accepting !== w.class_accepting)
                    report_mismatch("class_accepting", 64'(o_out_data.class_accepting),
                                    64'(w.class_accepting));
                if (o_out_data.class_active !== w.class_active)
                    report_mismatch("class_active", 64'(o_out_data.class_active),
                                    64'(w.class_active));
                if (o_out_data.class_weight !== w.class_weight)
                    report_mismatch("class_weight", 64'(o_out_data.class_weight),
                                    64'(w.class_weight));
            end
        end
    end

    // output stall: random, or held during a hold-off stretch
    always @(posedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else if (stall_bias == 0) i_out_stall <= 1'b0;
        else if ($urandom_range(0, 9) < stall_bias) i_out_stall <= 1'b1;
        else i_out_stall <= 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one command, hold it until taken, predict its result
    task automatic send_command(t_in_item it, int gap);
        repeat (gap + 1) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(schedule_command(it));
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_thresh(logic [47:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_THRESH; pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        thresh = v;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_cmd(t_mode m, int c, logic [15:0] p,
                                          logic [31:0] a, logic [15:0] w);
        t_in_item it;
        it.mode = m; it.class_index = c[3:0]; it.head_priority = p;
        it.amount = a; it.weight = w;
        return it;
    endfunction

    function automatic t_in_item random_cmd();
        t_in_item it;
        int r;
        it.mode = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        it.class_index = 4'((r < 70) ? $urandom_range(0, 5) : $urandom_range(0, 15));
        it.head_priority = 16'(($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(0, 3));
        r = $urandom_range(0, 9);
        it.amount = (r < 5) ? $urandom_range(0, 4095) : (r < 8) ? $urandom : 32'hFFFF_FFFF;
        r = $urandom_range(0, 9);
        it.weight = (r == 0) ? 16'd0 : (r < 6) ? 16'($urandom_range(64, 1024))
                                               : 16'($urandom);
        // favour the commands that keep classes busy
        r = $urandom_range(0, 99);
        if (r < 20) it.mode = MODE_SELECT;
        else if (r < 35) it.mode = MODE_CHARGE;
        else if (r < 45) it.mode = MODE_ACTIVATE;
        return it;
    endfunction

    // every command, extremes of the fields, refusals and unknown slots
    task automatic test_directed();
        send_command(make_cmd(MODE_SELECT, 0, 0, 0, 0), 0);
        send_command(make_cmd(MODE_ACTIVATE, 3, 0, 0, 256), 0);
        send_command(make_cmd(MODE_REMOVE, 0, 0, 0, 0), 0);
        send_command(make_cmd(MODE_ADMIT, 15, 0, 0, 16'hFFFF), 1);
        send_command(make_cmd(MODE_ADMIT, 0, 0, 0, 16'h0001), 0);
        send_command(make_cmd(MODE_ADMIT, 2, 0, 0, 16'h0000), 0);
        send_command(make_cmd(MODE_SET_PRIO, 15, 16'hFFFF, 0, 0), 0);
        send_command(make_cmd(MODE_ACTIVATE, 15, 16'hFFFF, 0, 0), 2);
        send_command(make_cmd(MODE_ACTIVATE, 0, 16'h0000, 0, 0), 0);
        send_command(make_cmd(MODE_CHARGE, 2, 0, 32'hFFFF_FFFF, 0), 0);
        send_command(make_cmd(MODE_ACTIVATE, 2, 16'h5555, 0, 0), 0);
        send_command(make_cmd(MODE_CHARGE, 2, 0, 32'hFFFF_FFFF, 16'h0000), 0);
        send_command(make_cmd(MODE_CHARGE, 15, 0, 32'hAAAA_AAAA, 16'hFFFF), 0);
        send_command(make_cmd(MODE_SELECT, 7, 0, 0, 0), 0);
        send_command(make_cmd(MODE_SET_PRIO, 15, 16'hAAAA, 0, 0), 0);
        send_command(make_cmd(MODE_SELECT, 0, 0, 0, 0), 5);
        send_command(make_cmd(MODE_REMOVE, 15, 0, 0, 0), 0);
        send_command(make_cmd(MODE_RETIRE, 15, 0, 0, 0), 0);
        send_command(make_cmd(MODE_RETIRE, 0, 0, 0, 0), 0);
        send_command(make_cmd(MODE_DEACTIVATE, 15, 0, 0, 0), 0);
        send_command(make_cmd(MODE_REMOVE, 15, 0, 0, 0), 0);
        send_command(make_cmd(MODE_DEACTIVATE, 2, 0, 0, 0), 0);
        send_command(make_cmd(MODE_DEACTIVATE, 0, 0, 0, 0), 0);
        send_command(make_cmd(MODE_CHARGE, 9, 0, 1, 1), 0);
        wait_drained();
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) send_command(random_cmd(), pick_gap());
        wait_drained();
    endtask

    // hold the receiver while commands keep coming, then release
    task automatic test_back_pressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 20; k++) send_command(random_cmd(), 0);
        join
        wait_drained();
    endtask

    // zero, small and maximum thresholds vary how often renormalisation runs
    task automatic test_thresholds();
        write_thresh(48'd0);
        test_random(120);
        write_thresh(48'h0000_0100_0000);
        test_random(120);
        write_thresh(VT_MAX);
        test_random(80);
        write_thresh(THRESH_RESET);
    endtask

    initial begin
        table_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        stall_bias = 0;
        test_random(60);
        stall_bias = 3;
        test_random(200);
        test_back_pressure();
        test_thresholds();
        if (error_count == 0)
            $display("weighted_fair_class_scheduler regression: pass");
        else
            $display("weighted_fair_class_scheduler regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("weighted_fair_class_scheduler regression: fail");
        $finish;
    end

endmodule

// ===== weighted_fair_class_scheduler.f =====
hw/rtl/wfcs_pkg.sv
hw/rtl/wfcs_divider.sv
hw/rtl/weighted_fair_class_scheduler.sv
sim/weighted_fair_class_scheduler_tb.sv
